FILE: rtl/core/pda_pkg.sv
package pda_pkg;

  // defaults for the top-level parameters
  localparam int RING_DEPTH_DEF = 8;
  localparam int TIME_BITS_DEF  = 32;

  localparam int EDGE_TIME_W = 32;
  localparam int ANGLE_W     = 15;
  localparam int SLOT_OUT_W  = 3;
  localparam int DUTY_W      = 16;
  localparam int QUOT_BITS   = 16;  // quotient bits per division
  localparam int PROD_W      = 31;  // (duty - min) * full angle
  localparam int TDATA_IN_W  = 32;
  localparam int TDATA_OUT_W = 24;
  localparam int TUSER_OUT_W = 2;

  // configuration port
  localparam int CFG_ADDR_W = 2;
  localparam int CFG_DATA_W = 16;
  localparam logic [CFG_ADDR_W-1:0] CFG_AUTOCAL_EN = 2'd0;
  localparam logic [CFG_ADDR_W-1:0] CFG_MIN_START  = 2'd1;
  localparam logic [CFG_ADDR_W-1:0] CFG_MAX_START  = 2'd2;

  // duty acceptance as percent of period: 1 .. 99
  localparam int RATIO_PCT = 100;
  localparam int RATIO_MAX = 99;

  // Q0.16 thresholds, integer approximations of the fractional limits
  localparam logic [DUTY_W-1:0] AUTOCAL_LO   = 16'd11796;  // duty > 0.18
  localparam logic [DUTY_W-1:0] AUTOCAL_HI   = 16'd64226;  // duty < 0.98
  localparam logic [DUTY_W-1:0] CAL_MIN_LIM  = 16'd16384;  // min < 0.25
  localparam logic [DUTY_W-1:0] CAL_MAX_LIM  = 16'd60293;  // max > 0.92
  localparam logic [DUTY_W-1:0] MIN_DUTY_RST = 16'hFFFF;
  localparam logic [DUTY_W-1:0] MAX_DUTY_RST = 16'h0000;

  localparam logic [ANGLE_W-1:0] FULL_ANGLE = 15'd23040;  // 360 deg in Q9.6

  typedef struct packed {
    logic rise;       // shift rise timestamps
    logic fall;       // capture fall timestamp
    logic div_start;
    logic div_angle;  // 0: duty division, 1: angle division
    logic cal;        // take duty from divider, widen min/max
    logic rng;        // capture duty - min
    logic mul;        // scale by full angle
    logic res_clr;    // result invalid, angle 0
    logic res_zero;   // result valid, angle 0
    logic res_angle;  // result valid, angle from divider
    logic out_load;
  } pda_cmd_t;

  typedef struct packed {
    logic duty_ok;
    logic div_done;
    logic range_ok;
    logic in_range;
    logic out_free;
  } pda_sts_t;

endpackage

FILE: rtl/core/pwm_duty_angle_decoder.sv
// PWM duty-cycle angle decoder. Each input item is a timestamped edge of the
// vane signal: a rising edge is absorbed without stalling the input and
// produces no output; a falling edge produces one output item with the Q9.6
// angle, its valid flag, the ring slot it belongs to and the calibration flag.
// A falling edge keeps the input stalled while the angle is computed, until
// its result is loaded into the output register. A rejected duty skips both
// divisions and an angle outside the calibrated range skips the second, and
// the stall grows while the previous result still waits in the output
// register. Both divisions use the shared 16-step restoring divider, once for
// high/period and once for the angle scale.
// The output register lets the next edge be accepted while a result waits.
module pwm_duty_angle_decoder
  import pda_pkg::*;
#(
  parameter int RING_DEPTH = RING_DEPTH_DEF,
  parameter int TIME_BITS  = TIME_BITS_DEF
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   s_axis_tvalid,
  output logic                   s_axis_tready,
  input  logic [TDATA_IN_W-1:0]  s_axis_tdata,   // [31:0] edge_time
  input  logic                   s_axis_tuser,   // [0] edge_level
  output logic                   m_axis_tvalid,
  input  logic                   m_axis_tready,
  output logic [TDATA_OUT_W-1:0] m_axis_tdata,   // [14:0] angle, [17:15] ring_slot
  output logic [TUSER_OUT_W-1:0] m_axis_tuser,   // [0] angle_valid, [1] calibrated
  input  logic                   cfg_we_i,
  input  logic [CFG_ADDR_W-1:0]  cfg_addr_i,
  input  logic [CFG_DATA_W-1:0]  cfg_wdata_i
);

  pda_cmd_t cmd;
  pda_sts_t sts;

  pda_ctrl u_ctrl (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .s_valid_i (s_axis_tvalid),
    .s_level_i (s_axis_tuser),
    .s_ready_o (s_axis_tready),
    .cmd_o     (cmd),
    .sts_i     (sts)
  );

  pda_datapath #(
    .RING_DEPTH (RING_DEPTH),
    .TIME_BITS  (TIME_BITS)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .edge_time_i (s_axis_tdata),
    .cfg_we_i    (cfg_we_i),
    .cfg_addr_i  (cfg_addr_i),
    .cfg_wdata_i (cfg_wdata_i),
    .m_valid_o   (m_axis_tvalid),
    .m_ready_i   (m_axis_tready),
    .m_data_o    (m_axis_tdata),
    .m_user_o    (m_axis_tuser)
  );

  // a falling edge occupies the sequencer
  a_fall_stalls: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready && !s_axis_tuser |=> !s_axis_tready)
    else $error("input ready after a falling edge");

  a_angle_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> m_axis_tdata[ANGLE_W-1:0] <= FULL_ANGLE)
    else $error("angle beyond full circle");

  a_invalid_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tuser[0] |-> m_axis_tdata[ANGLE_W-1:0] == '0)
    else $error("invalid result carries nonzero angle");

endmodule

FILE: rtl/core/pda_div.sv
module pda_div
  import pda_pkg::*;
#(
  parameter int DW = TIME_BITS_DEF
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 start_i,
  input  logic [DW-1:0]        divisor_i,
  input  logic [DW-1:0]        rem_init_i,  // must be below divisor
  input  logic [QUOT_BITS-1:0] dividend_lo_i,
  output logic                 done_o,
  output logic [QUOT_BITS-1:0] quot_o
);

  localparam int CNT_W = $clog2(QUOT_BITS);

  logic [DW-1:0]        div_q, rem_q, rem_d;
  logic [QUOT_BITS-1:0] lo_q, quo_q;
  logic [CNT_W-1:0]     cnt_q;
  logic                 busy_q, done_q;
  logic [DW:0]          shifted, diff;
  logic                 ge;

  // one restoring step per cycle
  assign shifted = {rem_q, lo_q[QUOT_BITS-1]};
  assign diff    = shifted - {1'b0, div_q};
  assign ge      = shifted >= {1'b0, div_q};
  assign rem_d   = ge ? diff[DW-1:0] : shifted[DW-1:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else if (start_i) begin
      busy_q <= 1'b1;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else if (busy_q) begin
      cnt_q <= cnt_q + 1'b1;
      if (cnt_q == CNT_W'(QUOT_BITS - 1)) begin
        busy_q <= 1'b0;
        done_q <= 1'b1;
      end
    end else begin
      done_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      div_q <= divisor_i;
      rem_q <= rem_init_i;
      lo_q  <= dividend_lo_i;
    end else if (busy_q) begin
      rem_q <= rem_d;
      lo_q  <= {lo_q[QUOT_BITS-2:0], 1'b0};
      quo_q <= {quo_q[QUOT_BITS-2:0], ge};
    end
  end

  assign done_o = done_q;
  assign quot_o = quo_q;

endmodule

FILE: rtl/core/pda_datapath.sv
module pda_datapath
  import pda_pkg::*;
#(
  parameter int RING_DEPTH = RING_DEPTH_DEF,
  parameter int TIME_BITS  = TIME_BITS_DEF
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  pda_cmd_t               cmd_i,
  output pda_sts_t               sts_o,
  input  logic [EDGE_TIME_W-1:0] edge_time_i,
  input  logic                   cfg_we_i,
  input  logic [CFG_ADDR_W-1:0]  cfg_addr_i,
  input  logic [CFG_DATA_W-1:0]  cfg_wdata_i,
  output logic                   m_valid_o,
  input  logic                   m_ready_i,
  output logic [TDATA_OUT_W-1:0] m_data_o,
  output logic [TUSER_OUT_W-1:0] m_user_o
);

  localparam int SW = $clog2(RING_DEPTH);
  localparam int CW = TIME_BITS + 7;  // room for 100 * time

  logic [TIME_BITS-1:0] prev_rise_q, last_rise_q, last_fall_q;
  logic [TIME_BITS-1:0] high, period;
  logic [CW-1:0]        high_x100, period_x99;
  logic [DUTY_W-1:0]    min_q, max_q, duty_q, diff_q, range, quot_duty;
  logic [PROD_W-1:0]    prod_q;
  logic                 autocal_q;
  logic [SW-1:0]        slot_q;
  logic [SW:0]          slot_inc;
  logic [ANGLE_W-1:0]   res_angle_q, out_angle_q;
  logic                 res_valid_q, out_valid_q;
  logic [SLOT_OUT_W-1:0] out_slot_q;
  logic                 out_cal_q, m_valid_q, calib;

  logic [TIME_BITS-1:0] div_divisor, div_rem;
  logic [QUOT_BITS-1:0] div_lo, div_quot;
  logic                 div_done;

  assign high       = last_fall_q - last_rise_q;
  assign period     = last_rise_q - prev_rise_q;
  assign high_x100  = CW'(high) * CW'(RATIO_PCT);
  assign period_x99 = CW'(period) * CW'(RATIO_MAX);
  assign range      = max_q - min_q;
  assign quot_duty  = div_quot[DUTY_W-1:0];
  assign calib      = (min_q < CAL_MIN_LIM) && (max_q > CAL_MAX_LIM);
  assign slot_inc   = {1'b0, slot_q} + 1'b1;

  always_comb begin
    if (cmd_i.div_angle) begin
      div_divisor = TIME_BITS'(range);
      div_rem     = TIME_BITS'(prod_q[PROD_W-1:QUOT_BITS]);
      div_lo      = prod_q[QUOT_BITS-1:0];
    end else begin
      // high < period here, so high << 16 yields a 16-bit quotient
      div_divisor = period;
      div_rem     = high;
      div_lo      = '0;
    end
  end

  pda_div #(
    .DW(TIME_BITS)
  ) u_div (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .start_i       (cmd_i.div_start),
    .divisor_i     (div_divisor),
    .rem_init_i    (div_rem),
    .dividend_lo_i (div_lo),
    .done_o        (div_done),
    .quot_o        (div_quot)
  );

  always_comb begin
    sts_o.duty_ok  = (period != '0) && (high_x100 >= CW'(period)) &&
                     (high_x100 <= period_x99);
    sts_o.div_done = div_done;
    sts_o.range_ok = max_q > min_q;
    sts_o.in_range = (duty_q >= min_q) && (duty_q <= max_q);
    sts_o.out_free = !m_valid_q || m_ready_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prev_rise_q <= '0;
      last_rise_q <= TIME_BITS'(1);
      last_fall_q <= '0;
      min_q       <= MIN_DUTY_RST;
      max_q       <= MAX_DUTY_RST;
      autocal_q   <= 1'b1;
      slot_q      <= '0;
      m_valid_q   <= 1'b0;
    end else begin
      if (cmd_i.rise) begin
        prev_rise_q <= last_rise_q;
        last_rise_q <= edge_time_i[TIME_BITS-1:0];
      end
      if (cmd_i.fall) begin
        last_fall_q <= edge_time_i[TIME_BITS-1:0];
      end
      if (cfg_we_i) begin
        case (cfg_addr_i)
          CFG_AUTOCAL_EN: autocal_q <= cfg_wdata_i[0];
          CFG_MIN_START:  min_q     <= cfg_wdata_i;
          CFG_MAX_START:  max_q     <= cfg_wdata_i;
          default:        ;
        endcase
      end else if (cmd_i.cal && autocal_q) begin
        if (min_q > quot_duty && quot_duty > AUTOCAL_LO) begin
          min_q <= quot_duty;
        end
        if (max_q < quot_duty && quot_duty < AUTOCAL_HI) begin
          max_q <= quot_duty;
        end
      end
      if (cmd_i.out_load) begin
        m_valid_q <= 1'b1;
        if (res_valid_q) begin
          slot_q <= (slot_inc >= (SW + 1)'(RING_DEPTH)) ? '0 : slot_inc[SW-1:0];
        end
      end else if (m_ready_i) begin
        m_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.cal) begin
      duty_q <= quot_duty;
    end
    if (cmd_i.rng) begin
      diff_q <= duty_q - min_q;
    end
    if (cmd_i.mul) begin
      prod_q <= PROD_W'(diff_q) * PROD_W'(FULL_ANGLE);
    end
    if (cmd_i.res_clr) begin
      res_angle_q <= '0;
      res_valid_q <= 1'b0;
    end else if (cmd_i.res_zero) begin
      res_angle_q <= '0;
      res_valid_q <= 1'b1;
    end else if (cmd_i.res_angle) begin
      res_angle_q <= div_quot[ANGLE_W-1:0];
      res_valid_q <= 1'b1;
    end
    if (cmd_i.out_load) begin
      out_angle_q <= res_angle_q;
      out_valid_q <= res_valid_q;
      out_slot_q  <= SLOT_OUT_W'(slot_q);
      out_cal_q   <= calib;
    end
  end

  assign m_valid_o = m_valid_q;
  assign m_data_o  = {(TDATA_OUT_W - SLOT_OUT_W - ANGLE_W)'(0), out_slot_q, out_angle_q};
  assign m_user_o  = {out_cal_q, out_valid_q};

endmodule

FILE: rtl/core/pda_ctrl.sv
module pda_ctrl
  import pda_pkg::*;
(
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     s_valid_i,
  input  logic     s_level_i,
  output logic     s_ready_o,
  output pda_cmd_t cmd_o,
  input  pda_sts_t sts_i
);

  typedef enum logic [8:0] {
    ST_IDLE  = 9'b000000001,
    ST_CHECK = 9'b000000010,
    ST_DIV1  = 9'b000000100,
    ST_CAL   = 9'b000001000,
    ST_RNG   = 9'b000010000,
    ST_MUL   = 9'b000100000,
    ST_DST   = 9'b001000000,
    ST_DIV2  = 9'b010000000,
    ST_OUT   = 9'b100000000
  } state_e;

  state_e state_q, state_d;

  always_comb begin
    state_d   = state_q;
    cmd_o     = '0;
    s_ready_o = 1'b0;
    case (state_q)
      ST_IDLE: begin
        s_ready_o = 1'b1;
        if (s_valid_i) begin
          if (s_level_i) begin
            cmd_o.rise = 1'b1;
          end else begin
            cmd_o.fall = 1'b1;
            state_d    = ST_CHECK;
          end
        end
      end
      ST_CHECK: begin
        if (sts_i.duty_ok) begin
          cmd_o.div_start = 1'b1;
          state_d         = ST_DIV1;
        end else begin
          cmd_o.res_clr = 1'b1;
          state_d       = ST_OUT;
        end
      end
      ST_DIV1: begin
        if (sts_i.div_done) begin
          state_d = ST_CAL;
        end
      end
      ST_CAL: begin
        cmd_o.cal = 1'b1;
        state_d   = ST_RNG;
      end
      ST_RNG: begin
        if (!sts_i.range_ok) begin
          cmd_o.res_clr = 1'b1;
          state_d       = ST_OUT;
        end else if (!sts_i.in_range) begin
          cmd_o.res_zero = 1'b1;
          state_d        = ST_OUT;
        end else begin
          cmd_o.rng = 1'b1;
          state_d   = ST_MUL;
        end
      end
      ST_MUL: begin
        cmd_o.mul = 1'b1;
        state_d   = ST_DST;
      end
      ST_DST: begin
        cmd_o.div_start = 1'b1;
        cmd_o.div_angle = 1'b1;
        state_d         = ST_DIV2;
      end
      ST_DIV2: begin
        cmd_o.div_angle = 1'b1;
        if (sts_i.div_done) begin
          cmd_o.res_angle = 1'b1;
          state_d         = ST_OUT;
        end
      end
      ST_OUT: begin
        if (sts_i.out_free) begin
          cmd_o.out_load = 1'b1;
          state_d        = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule
